// File: sv/rdfs_pkg.sv
// ----------------------------------------------------------------------------
// rdfs_pkg: shared types and constants of the maze carver
// Payload structs, status and datapath command codes, the direction shuffle.
// ----------------------------------------------------------------------------
package rdfs_pkg;

  // default sizes of the grid and the walk stack
  localparam int MAX_ROWS_DEF    = 32;
  localparam int MAX_COLS_DEF    = 32;
  localparam int STACK_DEPTH_DEF = 256;

  // configuration register width and reset values
  localparam int              CFG_W      = 6;
  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd11;
  localparam logic [CFG_W-1:0] COLS_RESET = 6'd21;

  // width of the coordinate fields in a result item
  localparam int OUT_W = 5;

  // register indexes on the configuration port
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OPENED      = 2'd0,
    STAT_NO_OPEN     = 2'd1,
    STAT_FINISHED    = 2'd2,
    STAT_NOT_STARTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  // input item
  typedef struct packed {
    logic       op;
    logic [7:0] random_choices;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [OUT_W-1:0] open_row;
    logic [OUT_W-1:0] open_col;
    status_e          status;
    logic             last;
  } res_t;

  // commands from controller to datapath
  typedef enum logic [3:0] {
    DP_NONE,
    DP_START,
    DP_CLEAR,
    DP_NOT_STARTED,
    DP_FINISHED,
    DP_POP,
    DP_LOAD,
    DP_TRY,
    DP_CHECK,
    DP_EMIT_NEW
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic running;
    logic empty;
    logic dirs_used;
    logic more_below;
    logic clear_last;
    logic opened;
  } dp_stat_t;

  // biased shuffle of {up, down, left, right}: position i swaps with choices[2i+1:2i]
  function automatic logic [7:0] shuffle(input logic [7:0] choices);
    logic [3:0][1:0] ord;
    logic [1:0]      j;
    logic [1:0]      t;
    ord = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};
    for (int i = 0; i < 4; i++) begin
      j      = choices[2*i +: 2];
      t      = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    return ord;
  endfunction

endpackage

// File: sv/rdfs_ctrl.sv
// ----------------------------------------------------------------------------
// rdfs_ctrl: sequencer of the maze carver
// Decodes an accepted item into datapath commands and walks the multi-cycle
// steps: visited map clear, stack top reload, neighbour check, second result.
// ----------------------------------------------------------------------------
module rdfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              op_i,
  input  rdfs_pkg::dp_stat_t stat_i,
  output rdfs_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_LOAD  = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT2 = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = rdfs_pkg::DP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (op_i == rdfs_pkg::OP_START) begin
            cmd_o.op = rdfs_pkg::DP_START;
            state_d  = S_CLEAR;
          end else if (!stat_i.running) begin
            cmd_o.op = rdfs_pkg::DP_NOT_STARTED;
          end else if (stat_i.empty) begin
            cmd_o.op = rdfs_pkg::DP_FINISHED;
          end else if (stat_i.dirs_used) begin
            cmd_o.op = rdfs_pkg::DP_POP;
            if (stat_i.more_below) begin
              state_d = S_LOAD;
            end
          end else begin
            cmd_o.op = rdfs_pkg::DP_TRY;
            state_d  = S_CHECK;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.op = rdfs_pkg::DP_CLEAR;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd_o.op = rdfs_pkg::DP_LOAD;
        state_d  = S_IDLE;
      end
      S_CHECK: begin
        cmd_o.op = rdfs_pkg::DP_CHECK;
        state_d  = stat_i.opened ? S_EMIT2 : S_IDLE;
      end
      S_EMIT2: begin
        cmd_o.op = rdfs_pkg::DP_EMIT_NEW;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // second result only follows a successful neighbour check
  a_emit2_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT2 |-> $past(state_q) == S_CHECK && $past(stat_i.opened))
    else $error("second result without an opened neighbour");

  // stack top reload only after a pop
  a_load_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> $past(cmd_o.op) == rdfs_pkg::DP_POP)
    else $error("stack top reload without pop");

endmodule

// File: sv/rdfs_dpath.sv
// ----------------------------------------------------------------------------
// rdfs_dpath: datapath of the maze carver
// Holds the stack top in registers, the entries below it and the visited map
// in synchronous memories, the stack count and the result register.
// ----------------------------------------------------------------------------
module rdfs_dpath #(
  parameter int MAX_ROWS    = rdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = rdfs_pkg::MAX_COLS_DEF,
  parameter int STACK_DEPTH = rdfs_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rdfs_pkg::dp_cmd_t           cmd_i,
  input  logic [7:0]                 choices_i,
  input  logic [rdfs_pkg::CFG_W-1:0] rows_cfg_i,
  input  logic [rdfs_pkg::CFG_W-1:0] cols_cfg_i,
  output rdfs_pkg::dp_stat_t          stat_o,
  output logic                       res_valid_o,
  output rdfs_pkg::res_t              res_o
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CLW  = $clog2(MAX_COLS);
  localparam int SW   = ((RW > CLW) ? RW : CLW) + 2;
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int OW   = rdfs_pkg::OUT_W;

  localparam logic signed [SW-1:0] STEP1 = SW'(1);
  localparam logic signed [SW-1:0] STEP2 = SW'(2);

  typedef struct packed {
    logic [RW-1:0]   row;
    logic [CLW-1:0]  col;
    logic [3:0][1:0] order;
    logic [2:0]      next;
  } entry_t;

  // control state
  logic [CNTW-1:0] count_q;
  logic            running_q;
  logic [RW-1:0]   clr_row_q;
  logic            res_valid_q;

  // payload state
  entry_t            top_q;
  logic [7:0]        choices_q;
  logic signed [SW-1:0] nrow_q, ncol_q, wrow_q, wcol_q;
  logic              in_bounds_q;
  rdfs_pkg::res_t     res_q, res_d;
  logic              emit;

  // memories
  logic [MAX_COLS-1:0] vis_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] vis_rdata_q;
  logic [MAX_COLS-1:0] vis_wdata;
  logic [RW-1:0]       vis_waddr;
  logic                vis_we;
  entry_t              stk_mem [STACK_DEPTH];
  entry_t              stk_rdata_q;

  // effective grid size and neighbour of the top cell
  logic signed [SW-1:0] rows_eff, cols_eff;
  logic signed [SW-1:0] trow, tcol, nrow, ncol, wrow, wcol;
  logic [1:0]           dir;
  logic                 in_bounds;
  logic                 clear_last, full, opened;

  assign rows_eff = (int'(rows_cfg_i) > MAX_ROWS) ? SW'(MAX_ROWS) : SW'(rows_cfg_i);
  assign cols_eff = (int'(cols_cfg_i) > MAX_COLS) ? SW'(MAX_COLS) : SW'(cols_cfg_i);

  always_comb begin
    dir  = top_q.order[top_q.next[1:0]];
    trow = SW'(top_q.row);
    tcol = SW'(top_q.col);
    nrow = trow;
    ncol = tcol;
    wrow = trow;
    wcol = tcol;
    case (dir)
      rdfs_pkg::DIR_UP: begin
        nrow = trow - STEP2;
        wrow = trow - STEP1;
      end
      rdfs_pkg::DIR_DOWN: begin
        nrow = trow + STEP2;
        wrow = trow + STEP1;
      end
      rdfs_pkg::DIR_LEFT: begin
        ncol = tcol - STEP2;
        wcol = tcol - STEP1;
      end
      default: begin
        ncol = tcol + STEP2;
        wcol = tcol + STEP1;
      end
    endcase
    in_bounds = (nrow > 0) && (nrow < rows_eff - STEP1) &&
                (ncol > 0) && (ncol < cols_eff - STEP1);
  end

  assign clear_last = (clr_row_q == RW'(MAX_ROWS - 1));
  assign full       = (int'(count_q) >= STACK_DEPTH);
  assign opened     = in_bounds_q && !vis_rdata_q[ncol_q[CLW-1:0]] && !full;

  assign stat_o.running    = running_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.dirs_used  = top_q.next[2];
  assign stat_o.more_below = (count_q > CNTW'(1));
  assign stat_o.clear_last = clear_last;
  assign stat_o.opened     = opened;

  // result selection and visited map writes
  always_comb begin
    emit      = 1'b0;
    res_d     = res_q;
    vis_we    = 1'b0;
    vis_waddr = clr_row_q;
    vis_wdata = '0;
    unique case (cmd_i.op)
      rdfs_pkg::DP_CLEAR: begin
        vis_we    = 1'b1;
        vis_wdata = (clr_row_q == RW'(1)) ? MAX_COLS'(2) : '0;
        if (clear_last) begin
          emit           = 1'b1;
          res_d.open_row = OW'(1);
          res_d.open_col = OW'(1);
          res_d.status   = rdfs_pkg::STAT_OPENED;
          res_d.last     = 1'b1;
        end
      end
      rdfs_pkg::DP_NOT_STARTED: begin
        emit           = 1'b1;
        res_d.open_row = '0;
        res_d.open_col = '0;
        res_d.status   = rdfs_pkg::STAT_NOT_STARTED;
        res_d.last     = 1'b1;
      end
      rdfs_pkg::DP_FINISHED: begin
        emit           = 1'b1;
        res_d.open_row = '0;
        res_d.open_col = '0;
        res_d.status   = rdfs_pkg::STAT_FINISHED;
        res_d.last     = 1'b1;
      end
      rdfs_pkg::DP_POP: begin
        emit           = 1'b1;
        res_d.open_row = OW'(top_q.row);
        res_d.open_col = OW'(top_q.col);
        res_d.status   = rdfs_pkg::STAT_NO_OPEN;
        res_d.last     = 1'b1;
      end
      rdfs_pkg::DP_CHECK: begin
        emit = 1'b1;
        if (opened) begin
          vis_we         = 1'b1;
          vis_waddr      = nrow_q[RW-1:0];
          vis_wdata      = vis_rdata_q | (MAX_COLS'(1) << ncol_q[CLW-1:0]);
          res_d.open_row = OW'(wrow_q);
          res_d.open_col = OW'(wcol_q);
          res_d.status   = rdfs_pkg::STAT_OPENED;
          res_d.last     = 1'b0;
        end else begin
          res_d.open_row = OW'(top_q.row);
          res_d.open_col = OW'(top_q.col);
          res_d.status   = rdfs_pkg::STAT_NO_OPEN;
          res_d.last     = 1'b1;
        end
      end
      rdfs_pkg::DP_EMIT_NEW: begin
        emit           = 1'b1;
        res_d.open_row = OW'(top_q.row);
        res_d.open_col = OW'(top_q.col);
        res_d.status   = rdfs_pkg::STAT_OPENED;
        res_d.last     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // visited map, one row per word
  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (cmd_i.op == rdfs_pkg::DP_TRY) begin
      vis_rdata_q <= vis_mem[nrow[RW-1:0]];
    end
  end

  // entries below the stack top
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rdfs_pkg::DP_CHECK && opened) begin
      stk_mem[AW'(count_q - CNTW'(1))] <= top_q;
    end
    if (cmd_i.op == rdfs_pkg::DP_POP) begin
      stk_rdata_q <= stk_mem[AW'(count_q - CNTW'(2))];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      running_q   <= 1'b0;
      clr_row_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
      unique case (cmd_i.op)
        rdfs_pkg::DP_START: begin
          clr_row_q <= '0;
        end
        rdfs_pkg::DP_CLEAR: begin
          clr_row_q <= clr_row_q + RW'(1);
          if (clear_last) begin
            count_q   <= CNTW'(1);
            running_q <= 1'b1;
          end
        end
        rdfs_pkg::DP_POP: begin
          count_q <= count_q - CNTW'(1);
        end
        rdfs_pkg::DP_CHECK: begin
          if (opened) begin
            count_q <= count_q + CNTW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stack top, neighbour and result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    unique case (cmd_i.op)
      rdfs_pkg::DP_START: begin
        choices_q <= choices_i;
      end
      rdfs_pkg::DP_CLEAR: begin
        if (clear_last) begin
          top_q.row   <= RW'(1);
          top_q.col   <= CLW'(1);
          top_q.order <= rdfs_pkg::shuffle(choices_q);
          top_q.next  <= '0;
        end
      end
      rdfs_pkg::DP_TRY: begin
        choices_q   <= choices_i;
        top_q.next  <= top_q.next + 3'd1;
        nrow_q      <= nrow;
        ncol_q      <= ncol;
        wrow_q      <= wrow;
        wcol_q      <= wcol;
        in_bounds_q <= in_bounds;
      end
      rdfs_pkg::DP_LOAD: begin
        top_q <= stk_rdata_q;
      end
      rdfs_pkg::DP_CHECK: begin
        if (opened) begin
          top_q.row   <= nrow_q[RW-1:0];
          top_q.col   <= ncol_q[CLW-1:0];
          top_q.order <= rdfs_pkg::shuffle(choices_q);
          top_q.next  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a wall result is always followed by the new cell
  a_wall_then_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |=>
      res_valid_q && res_q.last && res_q.status == rdfs_pkg::STAT_OPENED)
    else $error("wall result not followed by new cell");

  // an opened neighbour is pushed
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rdfs_pkg::DP_CHECK && opened |=> count_q == $past(count_q) + CNTW'(1))
    else $error("opened neighbour not pushed");

  // once started the walk stays started
  a_running_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |=> running_q)
    else $error("running flag dropped");

endmodule

// File: sv/random_dfs_maze_carver.sv
// ----------------------------------------------------------------------------
// random_dfs_maze_carver: randomized depth-first maze carver
// Results leave through a result register: a step result is formed from the
// accepted item, a neighbour check in the check state, its second result in
// the emit state. Busy is high, and no item is taken, during a pop's stack top
// reload from memory, a try's check (visited map read-modify-write), an opened
// cell's second result and the start sweep of the visited map, one row a cycle.
// Reset clears control state only; the visited map is swept on every start.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module random_dfs_maze_carver #(
  parameter int MAX_ROWS    = rdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = rdfs_pkg::MAX_COLS_DEF,
  parameter int STACK_DEPTH = rdfs_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  // item input
  input  logic           start,
  output logic           busy,
  input  rdfs_pkg::cmd_t  cmd_i,
  // result output
  output logic           res_valid_o,
  output rdfs_pkg::res_t  res_o
);

  logic [rdfs_pkg::CFG_W-1:0] rows_q, cols_q;
  rdfs_pkg::dp_cmd_t           dp_cmd;
  rdfs_pkg::dp_stat_t          dp_stat;
  logic                       cfg_wr;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= rdfs_pkg::ROWS_RESET;
      cols_q <= rdfs_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rdfs_pkg::REG_ROWS: rows_q <= pwdata[rdfs_pkg::CFG_W-1:0];
        rdfs_pkg::REG_COLS: cols_q <= pwdata[rdfs_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == rdfs_pkg::REG_COLS) ? 32'(cols_q) : 32'(rows_q);
  assign pready = 1'b1;

  // sequencer
  rdfs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (cmd_i.op),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy)
  );

  // walk datapath
  rdfs_dpath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .choices_i   (cmd_i.random_choices),
    .rows_cfg_i  (rows_q),
    .cols_cfg_i  (cols_q),
    .stat_o      (dp_stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
